@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// ASSERT_RST checks a property at each rising clock edge outside reset.
// ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/p422_pkg.sv @@
`timescale 1ns / 1ps

package p422_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  // One packed macropixel as it arrives.
  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } pix_t;

  // Classification of one macropixel, decided by the front end.
  typedef struct packed {
    logic even_row;
    logic drop_second;
    logic frame_end;
  } job_flags_t;

  localparam int unsigned JOB_FIXED_W = $bits(pix_t) + $bits(job_flags_t);

endpackage

@@ src/p422_jobq.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module p422_jobq #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written on each push transfer.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "job queue overfilled")
  `ASSERT_RST(a_push_not_full, clk_i, rst_ni, !(push_i && full_o), "push into a full job queue")

endmodule

@@ src/p422_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module p422_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned ADDR_BITS  = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [p422_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [p422_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  p422_pkg::pix_t                      pix_i,
  output logic                                job_push_o,
  input  logic                                job_full_i,
  output logic [ADDR_BITS-1:0]                job_y_addr_o,
  output logic [ADDR_BITS-1:0]                job_cb_addr_o,
  output logic [ADDR_BITS-1:0]                job_cr_addr_o,
  output p422_pkg::pix_t                      job_pix_o,
  output p422_pkg::job_flags_t                job_flags_o
);

  import p422_pkg::*;

  // Geometry width: holds a rounded stride of the widest picture.
  localparam int unsigned GEO_W  = 14;
  localparam int unsigned PROD_W = 2 * GEO_W;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned ROW_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // Settle count that holds full until the plane offsets are valid.
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [1:0]            settle_q;
  logic                  cfg_hit;

  logic [GEO_W-1:0]  eff_w, eff_h, pairs_d, ls_d, cs_d, h2_d;
  logic [GEO_W-1:0]  pairs_q, ls_q, cs_q, h_q;
  logic              w_odd_q;
  logic [PROD_W-1:0] prod_a_q, prod_b_q;
  logic [ADDR_BITS-1:0] cb_off_q, cr_off_q;

  logic [COL_W-1:0]     col_q;
  logic [ROW_W-1:0]     row_q;
  logic [ADDR_BITS-1:0] luma_base_q, blue_base_q, red_base_q;

  logic last_pair, ends_frame, even_row, restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);

  // Configuration registers and the settle counter that follows a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(640);
      height_q <= CFG_DATA_W'(480);
      settle_q <= SETTLE_CYCLES;
    end else begin
      if (cfg_valid_i && cfg_index_i == REG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == REG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      if (cfg_hit) begin
        settle_q <= SETTLE_CYCLES;
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // Clamped picture size and the strides derived from it.
  always_comb begin
    if (width_q == '0) begin
      eff_w = GEO_W'(1);
    end else if (GEO_W'(width_q) > GEO_W'(MAX_WIDTH)) begin
      eff_w = GEO_W'(MAX_WIDTH);
    end else begin
      eff_w = GEO_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = GEO_W'(1);
    end else if (GEO_W'(height_q) > GEO_W'(MAX_HEIGHT)) begin
      eff_h = GEO_W'(MAX_HEIGHT);
    end else begin
      eff_h = GEO_W'(height_q);
    end
    pairs_d = (eff_w + GEO_W'(1)) >> 1;
    ls_d    = (eff_w + GEO_W'(3)) & ~GEO_W'(3);
    cs_d    = (pairs_d + GEO_W'(3)) & ~GEO_W'(3);
    h2_d    = (eff_h + GEO_W'(1)) & ~GEO_W'(1);
  end

  // Geometry pipeline: products first, then the plane offsets.
  always_ff @(posedge clk_i) begin
    pairs_q  <= pairs_d;
    ls_q     <= ls_d;
    cs_q     <= cs_d;
    h_q      <= eff_h;
    w_odd_q  <= eff_w[0];
    prod_a_q <= PROD_W'(ls_d) * PROD_W'(h2_d);
    prod_b_q <= PROD_W'(cs_d) * PROD_W'(h2_d >> 1);
    cb_off_q <= ADDR_BITS'(prod_a_q);
    cr_off_q <= ADDR_BITS'(prod_a_q) + ADDR_BITS'(prod_b_q);
  end

  // Classification of the incoming macropixel.
  assign even_row   = !row_q[0];
  assign last_pair  = (GEO_W'(col_q) + GEO_W'(1)) >= pairs_q;
  assign ends_frame = last_pair && ((GEO_W'(row_q) + GEO_W'(1)) >= h_q);

  assign full_o     = (settle_q != '0) || job_full_i;
  assign job_push_o = push_i && !full_o;
  assign restart    = (settle_q != '0) || (job_push_o && ends_frame);

  assign job_y_addr_o  = luma_base_q + ADDR_BITS'({col_q, 1'b0});
  assign job_cb_addr_o = blue_base_q + ADDR_BITS'(col_q);
  assign job_cr_addr_o = red_base_q + ADDR_BITS'(col_q);
  assign job_pix_o     = pix_i;

  always_comb begin
    job_flags_o             = '0;
    job_flags_o.even_row    = even_row;
    job_flags_o.drop_second = last_pair && w_odd_q;
    job_flags_o.frame_end   = ends_frame;
  end

  // Frame position: column, row and the three row base addresses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      luma_base_q <= '0;
      blue_base_q <= '0;
      red_base_q  <= '0;
    end else if (restart) begin
      col_q       <= '0;
      row_q       <= '0;
      luma_base_q <= '0;
      blue_base_q <= cb_off_q;
      red_base_q  <= cr_off_q;
    end else if (job_push_o) begin
      if (last_pair) begin
        col_q       <= '0;
        row_q       <= row_q + ROW_W'(1);
        luma_base_q <= luma_base_q + ADDR_BITS'(ls_q);
        if (!even_row) begin
          blue_base_q <= blue_base_q + ADDR_BITS'(cs_q);
          red_base_q  <= red_base_q + ADDR_BITS'(cs_q);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  `ASSERT_RST(a_frame_wrap, clk_i, rst_ni,
    job_push_o && ends_frame |=> (col_q == '0 && row_q == '0 && luma_base_q == '0),
    "position did not return to the frame origin")
  `ASSERT_RST(a_col_range, clk_i, rst_ni,
    (settle_q == '0) |-> (GEO_W'(col_q) < pairs_q), "column ran past the row end")

endmodule

@@ src/p422_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module p422_back #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_pop_o,
  input  logic [ADDR_BITS-1:0]           job_y_addr_i,
  input  logic [ADDR_BITS-1:0]           job_cb_addr_i,
  input  logic [ADDR_BITS-1:0]           job_cr_addr_i,
  input  p422_pkg::pix_t                 job_pix_i,
  input  p422_pkg::job_flags_t           job_flags_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [ADDR_BITS-1:0]           write_address_o,
  output logic [p422_pkg::PIX_W-1:0]     write_byte_o,
  output logic [1:0]                     plane_o,
  output logic                           last_write_o,
  output logic                           frame_end_o
);

  import p422_pkg::*;

  localparam logic [1:0] STEP_Y0 = 2'd0;
  localparam logic [1:0] STEP_CB = 2'd1;
  localparam logic [1:0] STEP_Y1 = 2'd2;
  localparam logic [1:0] STEP_CR = 2'd3;

  localparam logic [1:0] PLANE_Y    = 2'd0;
  localparam logic [1:0] PLANE_CB   = 2'd1;
  localparam logic [1:0] PLANE_CR   = 2'd2;
  localparam logic [1:0] PLANE_RSVD = 2'd3;

  logic [ADDR_BITS-1:0] cur_y_q, cur_cb_q, cur_cr_q;
  pix_t                 cur_pix_q;
  job_flags_t           cur_flags_q;
  logic                 cur_valid_q;
  logic [1:0]           step_q;

  logic [3:0]           step_en;
  logic [1:0]           next_step;
  logic                 has_next;
  logic                 emit_fire;
  logic                 take_job;

  logic [ADDR_BITS-1:0] emit_addr;
  logic [PIX_W-1:0]     emit_byte;
  logic [1:0]           emit_plane;

  logic                 out_valid_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [PIX_W-1:0]     out_byte_q;
  logic [1:0]           out_plane_q;
  logic                 out_last_q;
  logic                 out_end_q;

  // Writes that this macropixel needs, and the next one after the current.
  always_comb begin
    step_en          = '0;
    step_en[STEP_Y0] = 1'b1;
    step_en[STEP_CB] = cur_flags_q.even_row;
    step_en[STEP_Y1] = !cur_flags_q.drop_second;
    step_en[STEP_CR] = cur_flags_q.even_row;
    next_step        = step_q;
    has_next         = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > step_q && step_en[i]) begin
        next_step = 2'(i);
        has_next  = 1'b1;
      end
    end
  end

  // Write selected by the current step.
  always_comb begin
    case (step_q)
      STEP_Y0: begin
        emit_addr  = cur_y_q;
        emit_byte  = cur_pix_q.luma_first;
        emit_plane = PLANE_Y;
      end
      STEP_CB: begin
        emit_addr  = cur_cb_q;
        emit_byte  = cur_pix_q.chroma_blue;
        emit_plane = PLANE_CB;
      end
      STEP_Y1: begin
        emit_addr  = {cur_y_q[ADDR_BITS-1:1], 1'b1};
        emit_byte  = cur_pix_q.luma_second;
        emit_plane = PLANE_Y;
      end
      STEP_CR: begin
        emit_addr  = cur_cr_q;
        emit_byte  = cur_pix_q.chroma_red;
        emit_plane = PLANE_CR;
      end
      default: begin
        emit_addr  = cur_y_q;
        emit_byte  = cur_pix_q.luma_first;
        emit_plane = PLANE_Y;
      end
    endcase
  end

  // A write moves to the output register when it is free or being taken.
  assign emit_fire = cur_valid_q && (!out_valid_q || pop_i);
  assign take_job  = !cur_valid_q || (emit_fire && !has_next);
  assign job_pop_o = take_job && job_valid_i;

  // Current job and step sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= STEP_Y0;
    end else if (take_job) begin
      cur_valid_q <= job_valid_i;
      step_q      <= STEP_Y0;
    end else if (emit_fire) begin
      step_q <= next_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_y_q     <= job_y_addr_i;
      cur_cb_q    <= job_cb_addr_i;
      cur_cr_q    <= job_cr_addr_i;
      cur_pix_q   <= job_pix_i;
      cur_flags_q <= job_flags_i;
    end
  end

  // Output register holding the oldest undelivered write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_addr_q  <= emit_addr;
      out_byte_q  <= emit_byte;
      out_plane_q <= emit_plane;
      out_last_q  <= !has_next;
      out_end_q   <= cur_flags_q.frame_end;
    end
  end

  assign empty_o         = !out_valid_q;
  assign write_address_o = out_addr_q;
  assign write_byte_o    = out_byte_q;
  assign plane_o         = out_plane_q;
  assign last_write_o    = out_last_q;
  assign frame_end_o     = out_end_q;

  `ASSERT_RST(a_plane_code, clk_i, rst_ni,
    out_valid_q |-> (out_plane_q != PLANE_RSVD), "reserved plane code on a result")
  `ASSERT_RST(a_odd_row_luma, clk_i, rst_ni,
    emit_fire && !cur_flags_q.even_row |-> (step_q == STEP_Y0 || step_q == STEP_Y1),
    "chroma write issued for an odd row")

endmodule

@@ src/packed_422_to_planar_420.sv @@
`timescale 1ns / 1ps
// Channel    | Direction | Handshake                 | Payload
// -----------+-----------+---------------------------+--------------------------------------
// input      | in        | push / full               | luma_first, chroma_blue, luma_second,
//            |           |                           | chroma_red
// result     | out       | empty / pop               | write_address, write_byte, plane,
//            |           |                           | last_write, frame_end
// config     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Results leave at one byte write per cycle through the single output register while pop
// is held, and a macropixel gives four writes on an even row (three when its second luma
// byte is dropped) and two on an odd row (one when it is dropped). Inputs are taken every
// cycle while the two-entry job queue has room. After reset and after each geometry
// register write, full stays high while the plane offset multipliers settle. The result
// side may stall at will; the input side then fills the job queue and raises full.

module packed_422_to_planar_420 #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned ADDR_BITS  = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [p422_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [p422_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [p422_pkg::PIX_W-1:0]      luma_first_i,
  input  logic [p422_pkg::PIX_W-1:0]      chroma_blue_i,
  input  logic [p422_pkg::PIX_W-1:0]      luma_second_i,
  input  logic [p422_pkg::PIX_W-1:0]      chroma_red_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ADDR_BITS-1:0]            write_address_o,
  output logic [p422_pkg::PIX_W-1:0]      write_byte_o,
  output logic [1:0]                      plane_o,
  output logic                            last_write_o,
  output logic                            frame_end_o
);

  import p422_pkg::*;

  localparam int unsigned JOB_W     = 3 * ADDR_BITS + JOB_FIXED_W;
  localparam int unsigned JOB_DEPTH = 2;

  pix_t                 pix;
  logic                 job_push, job_full, job_valid, job_pop;
  logic [ADDR_BITS-1:0] f_y_addr, f_cb_addr, f_cr_addr;
  logic [ADDR_BITS-1:0] b_y_addr, b_cb_addr, b_cr_addr;
  pix_t                 f_pix, b_pix;
  job_flags_t           f_flags, b_flags;
  logic [JOB_W-1:0]     q_in, q_out;

  // Gather the input fields into one macropixel.
  always_comb begin
    pix             = '0;
    pix.luma_first  = luma_first_i;
    pix.chroma_blue = chroma_blue_i;
    pix.luma_second = luma_second_i;
    pix.chroma_red  = chroma_red_i;
  end

  p422_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_o       (full),
    .pix_i        (pix),
    .job_push_o   (job_push),
    .job_full_i   (job_full),
    .job_y_addr_o (f_y_addr),
    .job_cb_addr_o(f_cb_addr),
    .job_cr_addr_o(f_cr_addr),
    .job_pix_o    (f_pix),
    .job_flags_o  (f_flags)
  );

  // Job queue between the classifier and the write sequencer.
  assign q_in = {f_y_addr, f_cb_addr, f_cr_addr, f_pix, f_flags};
  assign {b_y_addr, b_cb_addr, b_cr_addr, b_pix, b_flags} = q_out;

  p422_jobq #(
    .DEPTH(JOB_DEPTH),
    .WIDTH(JOB_W)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .full_o (job_full),
    .data_i (q_in),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (q_out)
  );

  p422_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_pop_o      (job_pop),
    .job_y_addr_i   (b_y_addr),
    .job_cb_addr_i  (b_cb_addr),
    .job_cr_addr_i  (b_cr_addr),
    .job_pix_i      (b_pix),
    .job_flags_i    (b_flags),
    .empty_o        (empty),
    .pop_i          (pop),
    .write_address_o(write_address_o),
    .write_byte_o   (write_byte_o),
    .plane_o        (plane_o),
    .last_write_o   (last_write_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

@@ tb/i420_write_check.sv @@
`timescale 1ns / 1ps

// Register indexes and plane codes shared by the testbench files.
package p422_tb_pkg;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SPARE_A      = 2'd2,
    REG_SPARE_B      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLANE_LUMA = 2'd0,
    PLANE_BLUE = 2'd1,
    PLANE_RED  = 2'd2
  } plane_e;

endpackage

// Watches the configuration, input and result channels, works out the planar byte
// writes that each accepted macropixel must produce and compares every result transfer
// with the oldest outstanding write.
module i420_write_check #(
  parameter int unsigned ADDR_BITS = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [p422_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [p422_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic [p422_pkg::PIX_W-1:0]      luma_first_i,
  input  logic [p422_pkg::PIX_W-1:0]      chroma_blue_i,
  input  logic [p422_pkg::PIX_W-1:0]      luma_second_i,
  input  logic [p422_pkg::PIX_W-1:0]      chroma_red_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic [ADDR_BITS-1:0]            write_address_i,
  input  logic [p422_pkg::PIX_W-1:0]      write_byte_i,
  input  logic [1:0]                      plane_i,
  input  logic                            last_write_i,
  input  logic                            frame_end_i,
  output int                              error_count_o,
  output int                              outstanding_o,
  output int                              writes_checked_o,
  output int                              frames_done_o
);
  import p422_pkg::*;
  import p422_tb_pkg::*;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [PIX_W-1:0]     data;
    plane_e               plane;
    logic                 last;
    logic                 frame_end;
  } byte_write_t;

  // Writes predicted but not yet seen on the result side, oldest first.
  byte_write_t expected_writes[$];

  // Geometry registers and the position within the destination frame.
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int unsigned           pair_col;
  int unsigned           row_idx;
  logic [ADDR_BITS-1:0]  luma_base;
  logic [ADDR_BITS-1:0]  blue_base;
  logic [ADDR_BITS-1:0]  red_base;

  int mismatches;
  int writes_checked;
  int frames_done;

  // A dimension of zero counts as one; anything above the maximum saturates.
  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int unsigned luma_stride();
    return (clamp_dim(width_reg, MAX_WIDTH) + 3) & ~32'd3;
  endfunction

  function automatic int unsigned chroma_stride();
    int unsigned half;
    half = ((clamp_dim(width_reg, MAX_WIDTH) + 1) & ~32'd1) / 2;
    return (half + 3) & ~32'd3;
  endfunction

  // Return to the top of the frame; the chroma planes follow the padded luma area.
  function automatic void restart_frame();
    int unsigned rows;
    int unsigned cb_off;
    int unsigned cr_off;
    rows   = (clamp_dim(height_reg, MAX_HEIGHT) + 1) & ~32'd1;
    cb_off = luma_stride() * rows;
    cr_off = cb_off + chroma_stride() * (rows / 2);
    pair_col  = 0;
    row_idx   = 0;
    luma_base = '0;
    blue_base = cb_off[ADDR_BITS-1:0];
    red_base  = cr_off[ADDR_BITS-1:0];
  endfunction

  function automatic byte_write_t make_write(logic [ADDR_BITS-1:0] address,
                                             logic [PIX_W-1:0] data, plane_e plane);
    byte_write_t wr;
    wr.address   = address;
    wr.data      = data;
    wr.plane     = plane;
    wr.last      = 1'b0;
    wr.frame_end = 1'b0;
    return wr;
  endfunction

  // Queue the writes of one macropixel and advance the frame position.
  function automatic void predict_writes(pix_t px);
    byte_write_t          batch [4];
    int                   n;
    int unsigned          w;
    int unsigned          h;
    int unsigned          luma_step;
    int unsigned          chroma_step;
    logic                 even_row;
    logic                 last_pair;
    logic                 drop_second;
    logic                 ends_frame;
    logic [ADDR_BITS-1:0] luma_addr;
    w           = clamp_dim(width_reg, MAX_WIDTH);
    h           = clamp_dim(height_reg, MAX_HEIGHT);
    luma_step   = luma_stride();
    chroma_step = chroma_stride();
    even_row    = (row_idx % 2) == 0;
    last_pair   = (pair_col + 1) >= (w + 1) / 2;
    drop_second = last_pair && (w % 2 == 1);
    ends_frame  = last_pair && (row_idx + 1 >= h);
    luma_addr   = luma_base + {pair_col[ADDR_BITS-2:0], 1'b0};

    // Even rows carry both chroma bytes; odd rows store luma alone.
    n = 0;
    batch[n] = make_write(luma_addr, px.luma_first, PLANE_LUMA);
    n = n + 1;
    if (even_row) begin
      batch[n] = make_write(blue_base + pair_col[ADDR_BITS-1:0], px.chroma_blue, PLANE_BLUE);
      n = n + 1;
    end
    if (!drop_second) begin
      batch[n] = make_write(luma_addr + 1'b1, px.luma_second, PLANE_LUMA);
      n = n + 1;
    end
    if (even_row) begin
      batch[n] = make_write(red_base + pair_col[ADDR_BITS-1:0], px.chroma_red, PLANE_RED);
      n = n + 1;
    end
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      batch[k].frame_end = ends_frame;
      expected_writes.push_back(batch[k]);
    end

    if (ends_frame) begin
      restart_frame();
      frames_done++;
    end else if (last_pair) begin
      pair_col  = 0;
      luma_base = luma_base + luma_step[ADDR_BITS-1:0];
      // Chroma rows only move on once both source rows of the pair are done.
      if (!even_row) begin
        blue_base = blue_base + chroma_step[ADDR_BITS-1:0];
        red_base  = red_base + chroma_step[ADDR_BITS-1:0];
      end
      row_idx++;
    end else begin
      pair_col++;
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one result transfer with the oldest outstanding write.
  function automatic void check_write();
    byte_write_t want;
    if (expected_writes.size() == 0) begin
      $display("%0t: unexpected write, address %0h byte %0h plane %0d", $time,
               write_address_i, write_byte_i, plane_i);
      mismatches++;
      return;
    end
    want = expected_writes.pop_front();
    writes_checked++;
    compare_field("write_address", 32'(want.address), 32'(write_address_i));
    compare_field("write_byte", 32'(want.data), 32'(write_byte_i));
    compare_field("plane", 32'(want.plane), 32'(plane_i));
    compare_field("last_write", 32'(want.last), 32'(last_write_i));
    compare_field("frame_end", 32'(want.frame_end), 32'(frame_end_i));
  endfunction

  // Transfers are taken in channel order; register writes only happen while idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      restart_frame();
      expected_writes.delete();
      mismatches     = 0;
      writes_checked = 0;
      frames_done    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data_i;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data_i;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (pop_i && !empty_i) check_write();
      if (push_i && !full_i)
        predict_writes({luma_first_i, chroma_blue_i, luma_second_i, chroma_red_i});
    end
    error_count_o    <= mismatches;
    outstanding_o    <= expected_writes.size();
    writes_checked_o <= writes_checked;
    frames_done_o    <= frames_done;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import p422_pkg::*;
  import p422_tb_pkg::*;

  localparam int unsigned ADDR_BITS        = 25;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 48;
  localparam int unsigned WATCHDOG_LIMIT   = 500;
  localparam int unsigned RANDOM_ITEMS     = 220;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  pix_t                  pixel     = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [ADDR_BITS-1:0]  write_address;
  logic [PIX_W-1:0]      write_byte;
  logic [1:0]            plane;
  logic                  last_write;
  logic                  frame_end;

  int error_count;
  int outstanding;
  int writes_checked;
  int frames_done;

  // Idling controls shared between the sending and receiving processes.
  bit          tx_stall_on  = 1'b1;
  bit          rx_stall_on  = 1'b1;
  bit          rx_long_hold = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned phases       = 0;
  int unsigned cfg_writes   = 0;

  packed_422_to_planar_420 #(
    .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .luma_first_i   (pixel.luma_first),
    .chroma_blue_i  (pixel.chroma_blue),
    .luma_second_i  (pixel.luma_second),
    .chroma_red_i   (pixel.chroma_red),
    .empty          (empty),
    .pop            (pop),
    .write_address_o(write_address),
    .write_byte_o   (write_byte),
    .plane_o        (plane),
    .last_write_o   (last_write),
    .frame_end_o    (frame_end)
  );

  i420_write_check #(
    .ADDR_BITS(ADDR_BITS)
  ) write_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push_i          (push),
    .full_i          (full),
    .luma_first_i    (pixel.luma_first),
    .chroma_blue_i   (pixel.chroma_blue),
    .luma_second_i   (pixel.luma_second),
    .chroma_red_i    (pixel.chroma_red),
    .empty_i         (empty),
    .pop_i           (pop),
    .write_address_i (write_address),
    .write_byte_i    (write_byte),
    .plane_i         (plane),
    .last_write_i    (last_write),
    .frame_end_i     (frame_end),
    .error_count_o   (error_count),
    .outstanding_o   (outstanding),
    .writes_checked_o(writes_checked),
    .frames_done_o   (frames_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bytes lean towards the extremes so that all-zero and all-one values turn up often.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t random_pixel();
    return {random_byte(), random_byte(), random_byte(), random_byte()};
  endfunction

  // Offer one macropixel after a random gap and hold it until the input transfer.
  task automatic send_pixel(pix_t px);
    int unsigned gap;
    gap = tx_stall_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel <= px;
    push  <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted write has come back.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid is left high so that back-to-back writes need no extra edge; callers lower it.
  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic apply_geometry(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] height,
                                bit with_spare, bit height_first);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if (with_spare)
      write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, junk);
    if (height_first) begin
      write_register(REG_FRAME_HEIGHT, height);
      write_register(REG_FRAME_WIDTH, width);
    end else begin
      write_register(REG_FRAME_WIDTH, width);
      write_register(REG_FRAME_HEIGHT, height);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: a random hold-off before each transfer, or one long stretch on request.
  initial begin : result_side
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = rx_stall_on ? $urandom_range(0, 9) : 0;
      if (rx_long_hold) begin
        gap          = LONG_HOLD_CYCLES;
        rx_long_hold = 1'b0;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned count;
    int unsigned w;
    int unsigned h;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry with extreme and alternating bit patterns.
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h55AA55AA);
    send_pixel(32'hAA55AA55);
    drain();

    // Odd width and height: dropped second luma byte, odd rows and a wrap past frame end.
    apply_geometry(13'd3, 13'd3, 1'b0, 1'b0);
    repeat (7) send_pixel(random_pixel());
    drain();

    // One pixel wide and two rows high: the odd row carries a single luma byte.
    apply_geometry(13'd1, 13'd2, 1'b0, 1'b1);
    repeat (3) send_pixel(random_pixel());
    drain();

    // Zero dimensions count as one, so every macropixel ends the frame.
    apply_geometry(13'd0, 13'd0, 1'b0, 1'b0);
    repeat (2) send_pixel(random_pixel());
    drain();

    // Oversized registers saturate; writes to unused indexes must not move the position.
    apply_geometry(13'h1FFF, 13'd4097, 1'b0, 1'b0);
    repeat (2) send_pixel(random_pixel());
    drain();
    write_register(REG_SPARE_A, 13'h1FFF);
    write_register(REG_SPARE_B, 13'h0000);
    cfg_valid <= 1'b0;
    send_pixel(random_pixel());
    drain();

    // Largest legal geometry.
    apply_geometry(13'd4096, 13'd4096, 1'b0, 1'b1);
    send_pixel(random_pixel());
    drain();

    // Random phases, mostly small frames so that frame ends come round often.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phases++;
      if ($urandom_range(0, 3) != 0) begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(0, 8191);
        h = $urandom_range(0, 8191);
      end
      tx_stall_on = ($urandom_range(0, 2) != 0);
      rx_stall_on = ($urandom_range(0, 2) != 0);
      apply_geometry(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0], $urandom_range(0, 3) == 0,
                     $urandom_range(0, 1) != 0);
      count = $urandom_range(8, 30);
      // One phase keeps offering items while the result side holds off, so full rises.
      if (phases == 2) begin
        tx_stall_on  = 1'b0;
        rx_long_hold = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
        // One phase pauses half way until every write has come back.
        if (phases == 4 && i == count / 2) drain();
        send_pixel(random_pixel());
        random_items++;
      end
      drain();
    end

    $display("Run covered %0d macropixels: directed geometry corners and %0d random phases,",
             items_sent, phases);
    $display("with %0d byte writes checked, %0d frame wraps and %0d register writes.",
             writes_checked, frames_done, cfg_writes);
    if (error_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ packed_422_to_planar_420.f @@
+incdir+src
src/p422_pkg.sv
src/p422_jobq.sv
src/p422_front.sv
src/p422_back.sv
src/packed_422_to_planar_420.sv
tb/i420_write_check.sv
tb/tb.sv
